[sv/iee_pkg.sv]
// Shared types and constants for the infix expression evaluator.
// Used by iee_muldiv and infix_expression_evaluator_top; no dependencies.
`default_nettype none

package iee_pkg;

	localparam int VALUE_WIDTH = 32;
	localparam int OUT_W       = 32;
	localparam int CNT_W       = $clog2(VALUE_WIDTH + 1);

	typedef logic [VALUE_WIDTH-1:0] val_t;
	typedef logic [CNT_W-1:0]       cnt_t;

	// character codes
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_MUL   = 8'h2A;
	localparam logic [7:0] CH_DIV   = 8'h2F;
	localparam logic [7:0] CH_EQ    = 8'h3D;

	// pending term operator
	localparam logic [1:0] OP_NONE = 2'd0;
	localparam logic [1:0] OP_MUL  = 2'd1;
	localparam logic [1:0] OP_DIV  = 2'd2;

	typedef struct packed {
		logic start;
		logic is_div;
	} md_req_t;

	typedef struct packed {
		logic done;
		logic div_zero;
	} md_rsp_t;

endpackage

`default_nettype wire

[sv/infix_expression_evaluator_top.sv]
// Top level of the infix expression evaluator: character decode, term/sum
// sequencer and result register. Depends on iee_pkg and iee_muldiv.
//
// channel | dir | fields
// s_*     | in  | s_tdata[7:0] = char_code
// m_*     | out | m_tdata[31:0] = value, m_tuser[0] = divide_by_zero
//
// Digits and ignored characters are taken in the idle state. An operator or
// '=' with no pending * or / goes through the finish state, '=' then through
// the emit state to load the result word; closing a * or / waits on the
// iee_muldiv shift-add / restoring-divide loop, which a zero divisor skips.
// s_tready is low while a character is being closed. Reset clears control
// state, not m_tdata; a word waiting on m_tready stalls only the next '='.
`default_nettype none

module infix_expression_evaluator_top
	import iee_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] char_code
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [OUT_W-1:0] m_tdata,   // [31:0] value
	output logic [0:0]       m_tuser    // [0] divide_by_zero
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_WAIT = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	localparam logic [2:0] ACT_MUL = 3'd0;
	localparam logic [2:0] ACT_DIV = 3'd1;
	localparam logic [2:0] ACT_ADD = 3'd2;
	localparam logic [2:0] ACT_SUB = 3'd3;
	localparam logic [2:0] ACT_EQ  = 3'd4;

	logic [1:0] state_q;
	logic [2:0] act_q;
	val_t       number_q;
	val_t       term_q;
	val_t       sum_q;
	logic [1:0] pend_op_q;
	logic       sign_q;
	logic       zdiv_q;
	logic       m_tvalid_q;
	logic [OUT_W-1:0] m_tdata_q;
	logic       m_tuser_q;

	logic       accept;
	logic       is_digit;
	logic       is_op;
	logic [2:0] act_d;
	logic       pend_md;
	logic       emit;
	val_t       sum_next;
	val_t       num_next;
	md_req_t    md_req;
	md_rsp_t    md_rsp;
	val_t       md_result;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign is_digit = (s_tdata >= CH_0) && (s_tdata <= CH_9);
	assign pend_md  = (pend_op_q == OP_MUL) || (pend_op_q == OP_DIV);

	always_comb begin
		is_op = 1'b1;
		act_d = ACT_EQ;
		unique case (s_tdata)
			CH_MUL:   act_d = ACT_MUL;
			CH_DIV:   act_d = ACT_DIV;
			CH_PLUS:  act_d = ACT_ADD;
			CH_MINUS: act_d = ACT_SUB;
			CH_EQ:    act_d = ACT_EQ;
			default:  is_op = 1'b0;
		endcase
	end

	assign num_next = (number_q << 3) + (number_q << 1) + val_t'(s_tdata - CH_0);
	assign sum_next = sign_q ? sum_q - term_q : sum_q + term_q;
	assign emit     = (state_q == ST_EMIT) && (!m_tvalid_q || m_tready);

	assign md_req.start  = accept && is_op && pend_md;
	assign md_req.is_div = (pend_op_q == OP_DIV);

	iee_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (md_req),
		.opa    (term_q),
		.opb    (number_q),
		.rsp    (md_rsp),
		.result (md_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			act_q      <= ACT_EQ;
			number_q   <= '0;
			term_q     <= '0;
			sum_q      <= '0;
			pend_op_q  <= OP_NONE;
			sign_q     <= 1'b0;
			zdiv_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (emit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && is_digit) begin
						number_q <= num_next;
					end else if (accept && is_op) begin
						act_q <= act_d;
						if (pend_md) begin
							state_q <= ST_WAIT;
						end else begin
							// no pending * or /: the number is the term
							term_q   <= number_q;
							number_q <= '0;
							state_q  <= ST_FIN;
						end
					end
				end
				ST_WAIT: begin
					if (md_rsp.done) begin
						term_q   <= md_result;
						number_q <= '0;
						zdiv_q   <= zdiv_q | md_rsp.div_zero;
						state_q  <= ST_FIN;
					end
				end
				ST_FIN: begin
					case (act_q)
						ACT_MUL: begin
							pend_op_q <= OP_MUL;
							state_q   <= ST_IDLE;
						end
						ACT_DIV: begin
							pend_op_q <= OP_DIV;
							state_q   <= ST_IDLE;
						end
						ACT_ADD, ACT_SUB: begin
							sum_q     <= sum_next;
							term_q    <= '0;
							pend_op_q <= OP_NONE;
							sign_q    <= (act_q == ACT_SUB);
							state_q   <= ST_IDLE;
						end
						default: begin
							sum_q   <= sum_next;
							term_q  <= '0;
							state_q <= ST_EMIT;
						end
					endcase
				end
				ST_EMIT: begin
					if (emit) begin
						// clear the expression once the word is loaded
						number_q  <= '0;
						term_q    <= '0;
						sum_q     <= '0;
						pend_op_q <= OP_NONE;
						sign_q    <= 1'b0;
						zdiv_q    <= 1'b0;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			m_tdata_q <= zdiv_q ? '0 : OUT_W'(sum_q);
			m_tuser_q <= zdiv_q;
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = m_tdata_q;
	assign m_tuser[0] = m_tuser_q;

	a_dz_value: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata == '0)
		else $error("divide by zero word carries a value");

	a_wait_pending: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WAIT |-> pend_op_q == OP_MUL || pend_op_q == OP_DIV)
		else $error("waiting on muldiv with no pending operator");

	a_emit_after_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == ST_EMIT) |-> $past(state_q == ST_FIN && act_q == ACT_EQ))
		else $error("result load entered without a closing '='");

endmodule

`default_nettype wire

[sv/iee_muldiv.sv]
// Iterative multiply / signed divide unit built around one shared adder.
// Depends on iee_pkg.
`default_nettype none

module iee_muldiv
	import iee_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire md_req_t req,
	input  wire val_t    opa,
	input  wire val_t    opb,
	output md_rsp_t      rsp,
	output val_t         result
);

	localparam logic [1:0] MD_IDLE = 2'd0;
	localparam logic [1:0] MD_RUN  = 2'd1;
	localparam logic [1:0] MD_FIX  = 2'd2;

	logic [1:0] state_q;
	cnt_t       cnt_q;
	logic       is_div_q;
	logic       neg_q;
	logic       done_q;
	logic       dz_q;
	val_t       acc_q;   // product or partial remainder
	val_t       sh_q;    // multiplicand or dividend/quotient
	val_t       opb_q;   // multiplier or divisor magnitude
	val_t       res_q;

	val_t mag_a;
	val_t mag_b;
	logic [VALUE_WIDTH:0] rem_sh;
	logic [VALUE_WIDTH:0] add_x;
	logic [VALUE_WIDTH:0] add_y;
	logic                 add_cin;
	logic [VALUE_WIDTH:0] add_s;

	assign mag_a  = opa[VALUE_WIDTH-1] ? (~opa) + val_t'(1) : opa;
	assign mag_b  = opb[VALUE_WIDTH-1] ? (~opb) + val_t'(1) : opb;
	assign rem_sh = {acc_q, sh_q[VALUE_WIDTH-1]};

	// shared adder: accumulate, trial subtract or final negate
	always_comb begin
		add_x   = {1'b0, acc_q};
		add_y   = {1'b0, sh_q};
		add_cin = 1'b0;
		if (state_q == MD_FIX) begin
			add_x   = '0;
			add_y   = ~{1'b0, sh_q};
			add_cin = 1'b1;
		end else if (is_div_q) begin
			add_x   = rem_sh;
			add_y   = ~{1'b0, opb_q};
			add_cin = 1'b1;
		end
	end

	assign add_s = add_x + add_y + {{VALUE_WIDTH{1'b0}}, add_cin};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= MD_IDLE;
			cnt_q    <= '0;
			is_div_q <= 1'b0;
			neg_q    <= 1'b0;
			done_q   <= 1'b0;
			dz_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				MD_IDLE: begin
					if (req.start) begin
						is_div_q <= req.is_div;
						neg_q    <= opa[VALUE_WIDTH-1] ^ opb[VALUE_WIDTH-1];
						if (req.is_div && mag_b == '0) begin
							done_q <= 1'b1;
							dz_q   <= 1'b1;
						end else begin
							dz_q    <= 1'b0;
							cnt_q   <= cnt_t'(VALUE_WIDTH);
							state_q <= MD_RUN;
						end
					end
				end
				MD_RUN: begin
					cnt_q <= cnt_q - cnt_t'(1);
					if (cnt_q == cnt_t'(1)) begin
						state_q <= MD_FIX;
					end
				end
				MD_FIX: begin
					done_q  <= 1'b1;
					state_q <= MD_IDLE;
				end
				default: begin
					state_q <= MD_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == MD_IDLE && req.start) begin
			acc_q <= '0;
			sh_q  <= req.is_div ? mag_a : opa;
			opb_q <= req.is_div ? mag_b : opb;
			if (req.is_div && mag_b == '0) begin
				res_q <= '0;
			end
		end else if (state_q == MD_RUN) begin
			if (is_div_q) begin
				// restoring step: keep the difference when it did not borrow
				if (!add_s[VALUE_WIDTH]) begin
					acc_q <= add_s[VALUE_WIDTH-1:0];
					sh_q  <= {sh_q[VALUE_WIDTH-2:0], 1'b1};
				end else begin
					acc_q <= rem_sh[VALUE_WIDTH-1:0];
					sh_q  <= {sh_q[VALUE_WIDTH-2:0], 1'b0};
				end
			end else begin
				if (opb_q[0]) begin
					acc_q <= add_s[VALUE_WIDTH-1:0];
				end
				sh_q  <= {sh_q[VALUE_WIDTH-2:0], 1'b0};
				opb_q <= {1'b0, opb_q[VALUE_WIDTH-1:1]};
			end
		end else if (state_q == MD_FIX) begin
			if (is_div_q) begin
				res_q <= neg_q ? add_s[VALUE_WIDTH-1:0] : sh_q;
			end else begin
				res_q <= acc_q;
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.div_zero = dz_q;
	assign result       = res_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> state_q == MD_IDLE)
		else $error("muldiv started while busy");

	a_run_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == MD_RUN |-> cnt_q != '0)
		else $error("muldiv running with exhausted count");

	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done && rsp.div_zero |-> result == '0)
		else $error("zero divisor gave nonzero quotient");

endmodule

`default_nettype wire
